>>> rtl/core/spf_pkg.sv
// ----------------------------------------------------------------------------
// spf_pkg: spring pair force types and constants
// shared widths, register indexes, pipeline payload and step functions
// ----------------------------------------------------------------------------
package spf_pkg;

    localparam int AXES       = 3;
    localparam int POS_W      = 32;
    localparam int DATA_W     = 2 * AXES * POS_W;
    localparam int IN_USER_W  = 2;
    localparam int OUT_USER_W = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int SQ_STEPS   = 32;
    localparam int DV_STEPS   = 64;

    localparam logic [31:0] ELLIPSE_ONE = 32'h0001_0000;
    localparam logic [30:0] AXIS_MAX    = 31'h7FFF_FFFF;
    localparam logic [40:0] FORCE_CAP   = 41'h100_0000_0000;
    localparam logic [56:0] SCALE_CAP   = 57'h100_0000_0000_0000;

    // tuser bit positions
    localparam int USR_FIRST_ANCHOR  = 0;
    localparam int USR_SECOND_ANCHOR = 1;
    localparam int USR_APPLY_FIRST   = 0;
    localparam int USR_APPLY_SECOND  = 1;
    localparam int USR_COLLIDED      = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPRING_GAIN = 3'd0,
        CFG_REST_LENGTH = 3'd1,
        CFG_ELLIPSE_X   = 3'd2,
        CFG_ELLIPSE_Y   = 3'd3,
        CFG_ELLIPSE_Z   = 3'd4
    } cfg_index_t;

    // control payload traveling with each pair
    typedef struct packed {
        logic                   near;
        logic                   zero;
        logic                   far;
        logic [1:0]             anchor;
        logic [AXES-1:0]        neg;
        logic [AXES-1:0][30:0]  sm;
    } ctl_t;

    typedef struct packed {
        logic [32:0] rem;
        logic [31:0] root;
        logic [63:0] val;
    } sqrt_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [63:0] num;
        logic [31:0] dvs;
    } div_t;

    // one digit of the square root
    function automatic sqrt_t sqrt_step(sqrt_t s);
        sqrt_t       r;
        logic [34:0] t;
        logic [34:0] trial;
        logic [34:0] df;
        t     = {s.rem, s.val[63:62]};
        trial = {1'b0, s.root, 2'b01};
        df    = t - trial;
        r.val = {s.val[61:0], 2'b00};
        if (t >= trial) begin
            r.rem  = df[32:0];
            r.root = {s.root[30:0], 1'b1};
        end else begin
            r.rem  = t[32:0];
            r.root = {s.root[30:0], 1'b0};
        end
        return r;
    endfunction

    // one quotient bit of the restoring divider
    function automatic div_t div_step(div_t s);
        div_t        r;
        logic [32:0] t;
        logic [32:0] df;
        logic        ge;
        t     = {s.rem, s.num[63]};
        ge    = (t >= {1'b0, s.dvs});
        df    = t - {1'b0, s.dvs};
        r.rem = ge ? df[31:0] : t[31:0];
        r.num = {s.num[62:0], ge};
        r.dvs = s.dvs;
        return r;
    endfunction

    // sign and saturate a force magnitude to a 32-bit field
    function automatic logic [31:0] to_field(logic neg, logic [41:0] m);
        logic [31:0] res;
        if (neg) begin
            if (m >= 42'h0_8000_0000) res = 32'h8000_0000;
            else                      res = ~m[31:0] + 32'd1;
        end else begin
            if (m > 42'h0_7FFF_FFFF)  res = 32'h7FFF_FFFF;
            else                      res = m[31:0];
        end
        return res;
    endfunction

endpackage

>>> rtl/core/spring_pair_force_unit.sv
// ----------------------------------------------------------------------------
// spring_pair_force_unit: pairwise spring force for force-directed layout
// one pair of particle positions in, forces on both particles out
// ----------------------------------------------------------------------------
// usage
//   s_ beats carry two 3-d positions (signed q16.16) and two anchor flags;
//   m_ beats carry the saturated forces on both particles, the apply flags
//   and the collision flag. the cfg channel writes gain, rest length and
//   the per-axis ellipse factors; write it only while no pair is in flight.
// throughput: one beat per cycle while the skid register is empty
// pipeline: stages s1..s4, the 32-stage square root (one root digit per
//   stage), d1, d2, the 64-stage restoring divider (one quotient bit per
//   stage), m1..m3 and the output register
// stall: the pipeline moves as one; a skid register behind the output
//   register catches one more beat after m_tready drops, then s_tready
//   falls until the skid drains. nothing is lost or repeated
// reset: synchronous; aresetn low empties the pipeline and loads
//   gain 0, rest length 0 and ellipse factors 1.0
// ----------------------------------------------------------------------------
module spring_pair_force_unit import spf_pkg::*; #(
    parameter int DIMENSIONS = 3
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z
    input  logic [DATA_W-1:0]     s_tdata,
    // first_anchor, second_anchor
    input  logic [IN_USER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // force_first_x/y/z, force_second_x/y/z
    output logic [DATA_W-1:0]     m_tdata,
    // apply_first, apply_second, collided
    output logic [OUT_USER_W-1:0] m_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]           cfg_data
);

    // configuration registers
    logic [31:0] gain_reg;
    logic [31:0] rest_reg;
    logic [31:0] ellipse_reg [AXES];
    logic [63:0] rest_sq_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg       <= '0;
            rest_reg       <= '0;
            ellipse_reg[0] <= ELLIPSE_ONE;
            ellipse_reg[1] <= ELLIPSE_ONE;
            ellipse_reg[2] <= ELLIPSE_ONE;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SPRING_GAIN: gain_reg       <= cfg_data;
                CFG_REST_LENGTH: rest_reg       <= cfg_data;
                CFG_ELLIPSE_X:   ellipse_reg[0] <= cfg_data;
                CFG_ELLIPSE_Y:   ellipse_reg[1] <= cfg_data;
                CFG_ELLIPSE_Z:   ellipse_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // cutoff square, registered from the rest length register
    always_ff @(posedge aclk) begin
        rest_sq_reg <= {32'd0, rest_reg} * {32'd0, rest_reg};
    end

    // whole pipeline advances unless the skid holds a beat
    logic adv;
    logic skid_valid_reg;

    assign adv      = !skid_valid_reg;
    assign s_tready = adv;

    // ------------------------------------------------------------------
    // stage 1: axis differences
    // ------------------------------------------------------------------
    logic [32:0]     diff [AXES];
    logic [31:0]     s1_mag_next [AXES];
    logic [AXES-1:0] s1_neg_next;
    logic            s1_same_next;

    always_comb begin
        s1_same_next = 1'b1;
        for (int i = 0; i < AXES; i++) begin
            diff[i] = {s_tdata[POS_W*i + POS_W-1], s_tdata[POS_W*i +: POS_W]}
                    - {s_tdata[POS_W*(AXES+i) + POS_W-1], s_tdata[POS_W*(AXES+i) +: POS_W]};
            if (i < DIMENSIONS) begin
                s1_neg_next[i] = diff[i][32];
                s1_mag_next[i] = diff[i][32] ? 32'(-diff[i]) : diff[i][31:0];
                if (diff[i] != 33'd0) s1_same_next = 1'b0;
            end else begin
                s1_neg_next[i] = 1'b0;
                s1_mag_next[i] = '0;
            end
        end
    end

    logic            s1_valid_reg;
    logic [31:0]     s1_mag_reg [AXES];
    logic [AXES-1:0] s1_neg_reg;
    logic            s1_same_reg;
    logic [1:0]      s1_anchor_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_mag_reg    <= s1_mag_next;
            s1_neg_reg    <= s1_neg_next;
            s1_same_reg   <= s1_same_next;
            s1_anchor_reg <= s_tuser;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: raw squares, ellipse scaling, per-axis cutoff
    // ------------------------------------------------------------------
    logic [63:0]     scaled [AXES];
    logic [63:0]     s2_sq_next [AXES];
    logic [30:0]     s2_sm_next [AXES];
    logic [AXES-1:0] s2_lt_next;

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            s2_sq_next[i] = {32'd0, s1_mag_reg[i]} * {32'd0, s1_mag_reg[i]};
            scaled[i]     = {32'd0, s1_mag_reg[i]} * {32'd0, ellipse_reg[i]};
            // saturate (mag * e) >> 16 to 31 bits
            s2_sm_next[i] = (scaled[i][63:47] != 17'd0) ? AXIS_MAX : scaled[i][46:16];
            s2_lt_next[i] = (i < DIMENSIONS) ? (s1_mag_reg[i] < rest_reg) : 1'b1;
        end
    end

    logic            s2_valid_reg;
    logic [63:0]     s2_sq_reg [AXES];
    logic [30:0]     s2_sm_reg [AXES];
    logic [AXES-1:0] s2_lt_reg;
    logic [AXES-1:0] s2_neg_reg;
    logic            s2_same_reg;
    logic [1:0]      s2_anchor_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_sq_reg     <= s2_sq_next;
            s2_sm_reg     <= s2_sm_next;
            s2_lt_reg     <= s2_lt_next;
            s2_neg_reg    <= s1_neg_reg;
            s2_same_reg   <= s1_same_reg;
            s2_anchor_reg <= s1_anchor_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: raw distance sum, scaled squares
    // ------------------------------------------------------------------
    logic [61:0] s3_ssq_next [AXES];

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            s3_ssq_next[i] = {31'd0, s2_sm_reg[i]} * {31'd0, s2_sm_reg[i]};
        end
    end

    logic            s3_valid_reg;
    logic [65:0]     s3_sum_reg;
    logic [61:0]     s3_ssq_reg [AXES];
    logic [30:0]     s3_sm_reg [AXES];
    logic [AXES-1:0] s3_lt_reg;
    logic [AXES-1:0] s3_neg_reg;
    logic            s3_same_reg;
    logic [1:0]      s3_anchor_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_sum_reg    <= {2'd0, s2_sq_reg[0]} + {2'd0, s2_sq_reg[1]} + {2'd0, s2_sq_reg[2]};
            s3_ssq_reg    <= s3_ssq_next;
            s3_sm_reg     <= s2_sm_reg;
            s3_lt_reg     <= s2_lt_reg;
            s3_neg_reg    <= s2_neg_reg;
            s3_same_reg   <= s2_same_reg;
            s3_anchor_reg <= s2_anchor_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 4 and square root pipe: d = floor(sqrt(sum of scaled squares))
    // ------------------------------------------------------------------
    ctl_t        s4_ctl_next;
    sqrt_t       s4_sq_next;

    always_comb begin
        s4_ctl_next.near   = (&s3_lt_reg) && (s3_sum_reg < {2'd0, rest_sq_reg});
        s4_ctl_next.zero   = s3_same_reg;
        s4_ctl_next.far    = 1'b0;
        s4_ctl_next.anchor = s3_anchor_reg;
        s4_ctl_next.neg    = s3_neg_reg;
        for (int i = 0; i < AXES; i++) begin
            s4_ctl_next.sm[i] = s3_sm_reg[i];
        end
        s4_sq_next.rem  = '0;
        s4_sq_next.root = '0;
        s4_sq_next.val  = s3_same_reg ? 64'd0
                        : {2'd0, s3_ssq_reg[0]} + {2'd0, s3_ssq_reg[1]}
                          + {2'd0, s3_ssq_reg[2]};
    end

    logic  sq_valid_reg [SQ_STEPS+1];
    sqrt_t sq_st_reg    [SQ_STEPS+1];
    ctl_t  sq_ctl_reg   [SQ_STEPS+1];

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_st_reg[0]  <= s4_sq_next;
            sq_ctl_reg[0] <= s4_ctl_next;
            for (int k = 0; k < SQ_STEPS; k++) begin
                sq_st_reg[k+1]  <= sqrt_step(sq_st_reg[k]);
                sq_ctl_reg[k+1] <= sq_ctl_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // d1: zero distance, side of rest length, |d - a|
    // ------------------------------------------------------------------
    logic [31:0] root_d;
    ctl_t        d1_ctl_next;

    assign root_d = sq_st_reg[SQ_STEPS].root;

    always_comb begin
        d1_ctl_next      = sq_ctl_reg[SQ_STEPS];
        d1_ctl_next.zero = sq_ctl_reg[SQ_STEPS].zero || (root_d == 32'd0);
        d1_ctl_next.far  = root_d > rest_reg;
    end

    logic        d1_valid_reg;
    ctl_t        d1_ctl_reg;
    logic [31:0] d1_dm_reg;
    logic [31:0] d1_d_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            d1_ctl_reg <= d1_ctl_next;
            d1_dm_reg  <= d1_ctl_next.far ? root_d - rest_reg : rest_reg - root_d;
            d1_d_reg   <= root_d;
        end
    end

    // ------------------------------------------------------------------
    // d2 and divider pipe: scale = (k * |d - a|) / d
    // ------------------------------------------------------------------
    div_t d2_dv_next;

    always_comb begin
        d2_dv_next.rem = '0;
        d2_dv_next.num = {32'd0, gain_reg} * {32'd0, d1_dm_reg};
        d2_dv_next.dvs = d1_d_reg;
    end

    logic dv_valid_reg [DV_STEPS+1];
    div_t dv_st_reg    [DV_STEPS+1];
    ctl_t dv_ctl_reg   [DV_STEPS+1];

    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_st_reg[0]  <= d2_dv_next;
            dv_ctl_reg[0] <= d1_ctl_reg;
            for (int k = 0; k < DV_STEPS; k++) begin
                dv_st_reg[k+1]  <= div_step(dv_st_reg[k]);
                dv_ctl_reg[k+1] <= dv_ctl_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // m1..m3: force magnitude = min((scale * s) >> 16, 2^40)
    // ------------------------------------------------------------------
    logic [63:0] quot;

    assign quot = dv_st_reg[DV_STEPS].num;

    logic        m1_valid_reg;
    ctl_t        m1_ctl_reg;
    logic [56:0] m1_scale_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            m1_ctl_reg   <= dv_ctl_reg[DV_STEPS];
            // a capped scale still caps every nonzero product
            m1_scale_reg <= (quot[63:56] != 8'd0) ? SCALE_CAP : quot[56:0];
        end
    end

    logic        m2_valid_reg;
    ctl_t        m2_ctl_reg;
    logic [62:0] m2_lo_reg [AXES];
    logic [55:0] m2_hi_reg [AXES];

    always_ff @(posedge aclk) begin
        if (adv) begin
            m2_ctl_reg <= m1_ctl_reg;
            for (int i = 0; i < AXES; i++) begin
                m2_lo_reg[i] <= {31'd0, m1_scale_reg[31:0]} * {32'd0, m1_ctl_reg.sm[i]};
                m2_hi_reg[i] <= {31'd0, m1_scale_reg[56:32]} * {25'd0, m1_ctl_reg.sm[i]};
            end
        end
    end

    logic [87:0] prod [AXES];
    logic [40:0] m3_mag_next [AXES];

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            prod[i] = {25'd0, m2_lo_reg[i]} + {m2_hi_reg[i], 32'd0};
            m3_mag_next[i] = (prod[i][87:16] > {31'd0, FORCE_CAP}) ? FORCE_CAP
                           : prod[i][56:16];
        end
    end

    logic        m3_valid_reg;
    ctl_t        m3_ctl_reg;
    logic [40:0] m3_mag_reg [AXES];

    always_ff @(posedge aclk) begin
        if (adv) begin
            m3_ctl_reg <= m2_ctl_reg;
            m3_mag_reg <= m3_mag_next;
        end
    end

    // valid bits move with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            d1_valid_reg <= 1'b0;
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
            m3_valid_reg <= 1'b0;
            for (int k = 0; k <= SQ_STEPS; k++) sq_valid_reg[k] <= 1'b0;
            for (int k = 0; k <= DV_STEPS; k++) dv_valid_reg[k] <= 1'b0;
        end else if (adv) begin
            s1_valid_reg    <= s_tvalid;
            s2_valid_reg    <= s1_valid_reg;
            s3_valid_reg    <= s2_valid_reg;
            sq_valid_reg[0] <= s3_valid_reg;
            for (int k = 0; k < SQ_STEPS; k++) sq_valid_reg[k+1] <= sq_valid_reg[k];
            d1_valid_reg    <= sq_valid_reg[SQ_STEPS];
            dv_valid_reg[0] <= d1_valid_reg;
            for (int k = 0; k < DV_STEPS; k++) dv_valid_reg[k+1] <= dv_valid_reg[k];
            m1_valid_reg    <= dv_valid_reg[DV_STEPS];
            m2_valid_reg    <= m1_valid_reg;
            m3_valid_reg    <= m2_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // result fields: sign, anchor doubling and zeroing, saturation
    // ------------------------------------------------------------------
    logic [DATA_W-1:0]     res_data;
    logic [OUT_USER_W-1:0] res_user;
    logic [41:0]           m_first  [AXES];
    logic [41:0]           m_second [AXES];
    logic                  sign_first [AXES];
    logic                  a1;
    logic                  a2;
    logic                  live;

    assign a1   = m3_ctl_reg.anchor[USR_FIRST_ANCHOR];
    assign a2   = m3_ctl_reg.anchor[USR_SECOND_ANCHOR];
    assign live = m3_ctl_reg.near && !m3_ctl_reg.zero;

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            m_first[i]    = a2 ? {m3_mag_reg[i], 1'b0} : {1'b0, m3_mag_reg[i]};
            m_second[i]   = a1 ? {m3_mag_reg[i], 1'b0} : {1'b0, m3_mag_reg[i]};
            sign_first[i] = m3_ctl_reg.neg[i] ^ m3_ctl_reg.far;
            res_data[POS_W*i +: POS_W] = (live && !a1)
                ? to_field(sign_first[i], m_first[i]) : 32'd0;
            res_data[POS_W*(AXES+i) +: POS_W] = (live && !a2)
                ? to_field(!sign_first[i], m_second[i]) : 32'd0;
        end
        if (!m3_ctl_reg.near) begin
            res_user = '0;
        end else if (m3_ctl_reg.zero) begin
            // coincident pair: caller adds noise
            res_user[USR_APPLY_FIRST]  = !a1;
            res_user[USR_APPLY_SECOND] = !a2 || a1;
            res_user[USR_COLLIDED]     = 1'b1;
        end else begin
            res_user[USR_APPLY_FIRST]  = !a1;
            res_user[USR_APPLY_SECOND] = !a2;
            res_user[USR_COLLIDED]     = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // output register and skid
    // ------------------------------------------------------------------
    logic                  out_valid_reg;
    logic [DATA_W-1:0]     out_data_reg;
    logic [OUT_USER_W-1:0] out_user_reg;
    logic [DATA_W-1:0]     skid_data_reg;
    logic [OUT_USER_W-1:0] skid_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!skid_valid_reg) begin
            if (!out_valid_reg || m_tready) begin
                out_valid_reg <= m3_valid_reg;
            end else if (m3_valid_reg) begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_tready) begin
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!skid_valid_reg) begin
            if (!out_valid_reg || m_tready) begin
                out_data_reg <= res_data;
                out_user_reg <= res_user;
            end else begin
                skid_data_reg <= res_data;
                skid_user_reg <= res_user;
            end
        end else if (m_tready) begin
            out_data_reg <= skid_data_reg;
            out_user_reg <= skid_user_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // the skid only fills behind a held output beat
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid beat without output beat");

    // a collision carries no force
    a_collided_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[USR_COLLIDED] |-> m_tdata == '0)
        else $error("force on a collided pair");

    // a first particle that is not moved gets no force
    a_first_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[USR_APPLY_FIRST] |-> m_tdata[POS_W*AXES-1:0] == '0)
        else $error("force on first particle without apply");

    // a skid beat moves into the output once the held beat is taken
    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && m_tready |=> out_valid_reg && !skid_valid_reg)
        else $error("skid beat lost");

endmodule
